// ===== rtl/core/mcosl_pkg.sv =====
// ----------------------------------------------------------------------------
// mcosl_pkg
// Shared types, sizes and helpers for the multi-channel one-shot limiter.
// ----------------------------------------------------------------------------
package mcosl_pkg;

   localparam int CHANNELS    = 16;
   localparam int TIME_BITS   = 16;

   localparam int CH_IN_W     = 5;
   localparam int DUR_IN_W    = 16;
   localparam int PULSE_CFG_W = 16;
   localparam int ACTIVE_CFG_W = 5;
   localparam int MASK_W      = 16;
   localparam int CNT_OUT_W   = 5;
   localparam int CNT_W       = $clog2(CHANNELS + 1);

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [PULSE_CFG_W-1:0]  PULSE_RESET  = 16'd1000;
   localparam logic [ACTIVE_CFG_W-1:0] ACTIVE_RESET = 5'd4;

   localparam logic [31:0] TIME_FULL = 32'((64'd1 << TIME_BITS) - 64'd1);

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_FIRE = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_PULSE_TIME = 1'b0,
      CSR_MAX_ACTIVE     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PULSE_CFG_W-1:0]  max_pulse_time;
      logic [ACTIVE_CFG_W-1:0] max_active;
   } cfg_type;

   // packed from the top down: drive_mask ends up in the lowest bits
   typedef struct packed {
      logic                 accepted;
      logic [CNT_OUT_W-1:0] active_count;
      logic                 status_led;
      logic [MASK_W-1:0]    drive_mask;
   } rsp_type;

   function automatic logic [CNT_W-1:0] popcount(input logic [CHANNELS-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         n = n + CNT_W'(v[i]);
      end
      return n;
   endfunction

endpackage

// ===== rtl/core/mcosl_core.sv =====
// ----------------------------------------------------------------------------
// mcosl_core
// Channel timers, drive bits and activity flag, updated once per item.
// ----------------------------------------------------------------------------
module mcosl_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 item_accept,
   input  mcosl_pkg::op_type                    op,
   input  logic [mcosl_pkg::CH_IN_W-1:0]        channel,
   input  logic [mcosl_pkg::DUR_IN_W-1:0]       duration,
   input  mcosl_pkg::cfg_type                   cfg,
   output mcosl_pkg::rsp_type                   result
);

   logic [mcosl_pkg::CHANNELS-1:0][mcosl_pkg::TIME_BITS-1:0] remaining_ff, remaining_in;
   logic [mcosl_pkg::CHANNELS-1:0] active_ff, active_in;
   logic                           flag_ff, flag_in;
   logic [mcosl_pkg::CNT_W-1:0]    count_ff, count_in;

   logic [mcosl_pkg::CHANNELS-1:0] sel;
   logic [31:0]                    lim;
   logic [31:0]                    clip;
   logic                           can_fire;

   always_comb begin
      for (int c = 0; c < mcosl_pkg::CHANNELS; c++) begin
         sel[c] = (32'(channel) == c);
      end

      lim  = (32'(cfg.max_pulse_time) > mcosl_pkg::TIME_FULL) ?
             mcosl_pkg::TIME_FULL : 32'(cfg.max_pulse_time);
      clip = (32'(duration) > lim) ? lim : 32'(duration);

      can_fire = (op == mcosl_pkg::OP_FIRE) && (|(sel & ~active_ff)) &&
                 (32'(count_ff) < 32'(cfg.max_active));

      active_in    = active_ff;
      remaining_in = remaining_ff;
      flag_in      = flag_ff;

      if (op == mcosl_pkg::OP_FIRE) begin
         if (can_fire) begin
            for (int c = 0; c < mcosl_pkg::CHANNELS; c++) begin
               if (sel[c]) begin
                  active_in[c]    = 1'b1;
                  remaining_in[c] = clip[mcosl_pkg::TIME_BITS-1:0];
               end
            end
            flag_in = 1'b1;
         end
      end else begin
         for (int c = 0; c < mcosl_pkg::CHANNELS; c++) begin
            if (active_ff[c]) begin
               if (remaining_ff[c] == '0) begin
                  active_in[c] = 1'b0;
               end else begin
                  remaining_in[c] = remaining_ff[c] - mcosl_pkg::TIME_BITS'(1);
               end
            end
         end
         flag_in = flag_ff & (|active_in);
      end

      count_in = mcosl_pkg::popcount(active_in);

      result.drive_mask = '0;
      for (int c = 0; c < mcosl_pkg::MASK_W; c++) begin
         if (c < mcosl_pkg::CHANNELS) begin
            result.drive_mask[c] = active_in[c];
         end
      end
      result.status_led   = flag_in;
      result.active_count = mcosl_pkg::CNT_OUT_W'(count_in);
      result.accepted     = can_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         active_ff    <= '0;
         flag_ff      <= 1'b0;
         count_ff     <= '0;
      end else if (item_accept) begin
         remaining_ff <= remaining_in;
         active_ff    <= active_in;
         flag_ff      <= flag_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ===== rtl/core/mcosl_skid.sv =====
// ----------------------------------------------------------------------------
// mcosl_skid
// Two-entry result buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
module mcosl_skid (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  mcosl_pkg::rsp_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output mcosl_pkg::rsp_type out_data
);

   logic               main_valid_ff, main_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   mcosl_pkg::rsp_type main_ff, main_in;
   mcosl_pkg::rsp_type skid_ff, skid_in;
   logic               push;
   logic               pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      push          = in_valid && !skid_valid_ff;
      pop           = main_valid_ff && out_ready;
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;

      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== rtl/core/multi_channel_one_shot_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_one_shot_limiter_unit
// Bank of one-shot drivers with a concurrency limit, stepped by tick and
// fire items.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser op, tdata channel+duration
//   rsp      out        rsp_tvalid/rsp_tready  tdata mask, led, count, accepted
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item per cycle while req_tready is high; its result is registered on acceptance.
// All timers, the drive bits and the live count update together on each accepted item.
// Synchronous reset clears every timer and flag.
// A two-entry result buffer keeps req open while one result waits;
// req_tready drops only when both entries are held.
// ----------------------------------------------------------------------------
module multi_channel_one_shot_limiter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mcosl_pkg::REQ_TDATA_W-1:0]   req_tdata,  // channel[4:0], duration[20:5]
   input  logic                                req_tuser,  // op[0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mcosl_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // drive_mask[15:0], status_led[16],
                                                           // active_count[21:17], accepted[22]
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcosl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mcosl_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [mcosl_pkg::PULSE_CFG_W-1:0]  max_pulse_time_ff;
   logic [mcosl_pkg::ACTIVE_CFG_W-1:0] max_active_ff;
   mcosl_pkg::cfg_type                 cfg;
   mcosl_pkg::rsp_type                 result;
   mcosl_pkg::rsp_type                 rsp_data;
   logic                               item_accept;

   assign csr_ready   = 1'b1;
   assign item_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pulse_time_ff <= mcosl_pkg::PULSE_RESET;
         max_active_ff     <= mcosl_pkg::ACTIVE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (mcosl_pkg::csr_index_type'(csr_index))
            mcosl_pkg::CSR_MAX_PULSE_TIME: begin
               max_pulse_time_ff <= csr_data[mcosl_pkg::PULSE_CFG_W-1:0];
            end
            mcosl_pkg::CSR_MAX_ACTIVE: begin
               max_active_ff <= csr_data[mcosl_pkg::ACTIVE_CFG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.max_pulse_time = max_pulse_time_ff;
   assign cfg.max_active     = max_active_ff;

   mcosl_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .op          (mcosl_pkg::op_type'(req_tuser)),
      .channel     (req_tdata[mcosl_pkg::CH_IN_W-1:0]),
      .duration    (req_tdata[mcosl_pkg::CH_IN_W +: mcosl_pkg::DUR_IN_W]),
      .cfg         (cfg),
      .result      (result)
   );

   mcosl_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = mcosl_pkg::RSP_TDATA_W'(rsp_data);

endmodule

// ===== rtl/core/mcosl_checker.sv =====
// ----------------------------------------------------------------------------
// mcosl_checker
// Port-level checks on the limiter results, bound to the top level.
// ----------------------------------------------------------------------------
module mcosl_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [mcosl_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   mcosl_pkg::rsp_type rsp;
   assign rsp = mcosl_pkg::rsp_type'(rsp_tdata[$bits(mcosl_pkg::rsp_type)-1:0]);

   // an accepted fire leaves at least one channel driven and the flag lit
   a_accept_lights: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.accepted |-> rsp.status_led && (rsp.active_count != '0))
      else $error("accepted fire without activity");

   // the flag stays lit while any channel is driven
   a_flag_covers_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.drive_mask != '0) |-> rsp.status_led)
      else $error("driven channel with flag clear");

   // live count matches the drive bits
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp.active_count) == $countones(rsp.drive_mask)))
      else $error("active count disagrees with drive mask");

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled item changed");

endmodule

bind multi_channel_one_shot_limiter_unit mcosl_checker u_checker (.*);

// ===== test/multi_channel_one_shot_limiter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// multi_channel_one_shot_limiter_unit_tb
// Self-checking bench for the one-shot limiter. A short table of fire and tick
// items with register writes opens the run. Rows with an obvious outcome carry
// their result, and every other row goes through a timer-bank predictor. Random
// phases follow, each with its own pulse cap, concurrency limit and idling
// pattern. Results are checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module multi_channel_one_shot_limiter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcosl_pkg::*;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct {
      row_kind_type   kind;
      csr_index_type  sel;
      logic [15:0]    value;
      op_type         op;
      logic [4:0]     ch;
      logic [15:0]    dur;
      logic           fixed;
      rsp_type        want;
   } plan_row_type;

   localparam rsp_type QUIET_RSP   = '0;
   localparam int      RANDOM_ITEMS = 1850;
   localparam int      LONG_HOLD    = 300;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata  = '0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]    csr_data   = '0;

   // predicted timer bank
   logic [15:0]          tick_left [CHANNELS];
   logic [CHANNELS-1:0]  driven_bits = '0;
   logic                 led_state   = 1'b0;
   logic [15:0]          pulse_cap   = 16'd1000;
   logic [4:0]           active_cap  = 5'd4;

   rsp_type expected_q [$];
   int      fail_count   = 0;
   int      items_sent   = 0;
   int      source_mode  = 1;
   int      sink_mode    = 1;
   int      holds_asked  = 0;
   int      holds_taken  = 0;
   int      hold_left    = 0;
   int      stall_left   = 0;

   plan_row_type plan [24] = '{
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_TICK, 5'd0,  16'd0,     1'b1, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd0,  16'd0,     1'b1,
        '{1'b1, 5'd1, 1'b1, 16'h0001}},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd0,  16'hFFFF,  1'b1,
        '{1'b0, 5'd1, 1'b1, 16'h0001}},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd31, 16'hFFFF,  1'b1,
        '{1'b0, 5'd1, 1'b1, 16'h0001}},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd16, 16'd0,     1'b1,
        '{1'b0, 5'd1, 1'b1, 16'h0001}},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_TICK, 5'd31, 16'hFFFF,  1'b1, QUIET_RSP},
      '{ROW_CSR,  CSR_MAX_PULSE_TIME, 16'd2, OP_TICK, 5'd0,  16'd0,     1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd15, 16'hFFFF,  1'b1,
        '{1'b1, 5'd1, 1'b1, 16'h8000}},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd1,  16'd1,     1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd2,  16'd2,     1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd3,  16'd0,     1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd4,  16'd3,     1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_TICK, 5'd0,  16'd0,     1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_TICK, 5'd0,  16'd0,     1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_TICK, 5'd0,  16'd0,     1'b0, QUIET_RSP},
      '{ROW_CSR,  CSR_MAX_ACTIVE,     16'd0, OP_TICK, 5'd0,  16'd0,     1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd5,  16'd10,    1'b0, QUIET_RSP},
      '{ROW_CSR,  CSR_MAX_PULSE_TIME, 16'hFFFF, OP_TICK, 5'd0, 16'd0,   1'b0, QUIET_RSP},
      '{ROW_CSR,  CSR_MAX_ACTIVE,     16'd16, OP_TICK, 5'd0, 16'd0,     1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd6,  16'd20,    1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_FIRE, 5'd7,  16'd0,     1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_TICK, 5'd0,  16'd0,     1'b0, QUIET_RSP},
      '{ROW_ITEM, CSR_MAX_PULSE_TIME, 16'd0, OP_TICK, 5'd0,  16'd0,     1'b0, QUIET_RSP},
      '{ROW_CSR,  CSR_MAX_PULSE_TIME, 16'd0, OP_TICK, 5'd0,  16'd0,     1'b0, QUIET_RSP}
   };

   multi_channel_one_shot_limiter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap(input int mode);
      int r;
      r = $urandom_range(0, 99);
      if (mode == 0) begin
         return 0;
      end else if (mode == 1) begin
         if (r < 70) return 0;
         if (r < 95) return $urandom_range(1, 3);
         return $urandom_range(10, 40);
      end
      if (r < 35) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic int live_channels();
      int n;
      n = 0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (driven_bits[c]) n++;
      end
      return n;
   endfunction

   function automatic rsp_type step_timer_bank(input op_type op, input logic [4:0] ch,
                                               input logic [15:0] dur);
      rsp_type r;
      logic    hit;
      hit = 1'b0;
      if (op == OP_FIRE) begin
         if (ch < CHANNELS && live_channels() < active_cap && !driven_bits[ch[3:0]]) begin
            tick_left[ch[3:0]]   = (dur > pulse_cap) ? pulse_cap : dur;
            driven_bits[ch[3:0]] = 1'b1;
            led_state            = 1'b1;
            hit                  = 1'b1;
         end
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (driven_bits[c]) begin
               if (tick_left[c] == 16'd0) driven_bits[c] = 1'b0;
               else tick_left[c] = tick_left[c] - 16'd1;
            end
         end
         if (live_channels() == 0) led_state = 1'b0;
      end
      r.drive_mask   = driven_bits;
      r.status_led   = led_state;
      r.active_count = 5'(live_channels());
      r.accepted     = hit;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= 40) begin
         $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
      end
   endtask

   task automatic check_result(input logic [RSP_TDATA_W-1:0] data);
      rsp_type got;
      rsp_type want;
      got = rsp_type'(data[RSP_TDATA_W-2:0]);
      if (expected_q.size() == 0) begin
         report_mismatch("result with nothing pending", 32'(data), 32'd0);
         return;
      end
      want = expected_q.pop_front();
      if (got.drive_mask !== want.drive_mask)
         report_mismatch("drive_mask", 32'(got.drive_mask), 32'(want.drive_mask));
      if (got.status_led !== want.status_led)
         report_mismatch("status_led", 32'(got.status_led), 32'(want.status_led));
      if (got.active_count !== want.active_count)
         report_mismatch("active_count", 32'(got.active_count), 32'(want.active_count));
      if (got.accepted !== want.accepted)
         report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata);
   end

   // result sink with random stalls and the occasional long hold-off
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holds_taken != holds_asked) begin
         holds_taken = holds_asked;
         hold_left   = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         gap = pick_gap(sink_mode);
         if (gap == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left = gap - 1;
         end
      end
   end

   task automatic send_item(input op_type op, input logic [4:0] ch, input logic [15:0] dur,
                            input logic fixed, input rsp_type want);
      rsp_type predicted;
      int      gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, dur, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = step_timer_bank(op, ch, dur);
      expected_q.push_back(fixed ? want : predicted);
      items_sent++;
      gap = pick_gap(source_mode);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type sel, input logic [15:0] value);
      wait_idle();
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (sel == CSR_MAX_PULSE_TIME) pulse_cap = value;
      else active_cap = value[4:0];
   endtask

   task automatic send_tick();
      send_item(OP_TICK, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
                1'b0, QUIET_RSP);
   endtask

   initial begin
      int          phase;
      int          span;
      int          fire_pct;
      int          random_start;
      int          r;
      logic [4:0]  ch;
      logic [15:0] dur;
      logic [15:0] cap;

      for (int c = 0; c < CHANNELS; c++) tick_left[c] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_register(plan[i].sel, plan[i].value);
         else send_item(plan[i].op, plan[i].ch, plan[i].dur, plan[i].fixed, plan[i].want);
      end

      phase        = 0;
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         r = $urandom_range(0, 5);
         case (r)
            0: cap = 16'd0;
            1: cap = 16'hFFFF;
            2: cap = 16'($urandom_range(1, 8));
            5: cap = 16'($urandom_range(64, 65534));
            default: cap = 16'($urandom_range(1, 40));
         endcase
         write_register(CSR_MAX_PULSE_TIME, cap);
         r = $urandom_range(0, 4);
         case (r)
            0: write_register(CSR_MAX_ACTIVE, 16'd0);
            1: write_register(CSR_MAX_ACTIVE, 16'd16);
            default: write_register(CSR_MAX_ACTIVE, 16'($urandom_range(1, 15)));
         endcase
         source_mode = $urandom_range(0, 2);
         sink_mode   = $urandom_range(0, 2);
         fire_pct    = $urandom_range(30, 90);
         span        = $urandom_range(30, 120);
         for (int n = 0; n < span; n++) begin
            // block fills and back-pressures the request side
            if (phase == 2 && n == 10) holds_asked++;
            if ($urandom_range(1, 100) <= fire_pct) begin
               ch = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                                : 5'($urandom_range(0, 15));
               // long pulses only where the cap clips them
               if (pulse_cap <= 16'd64) begin
                  dur = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, pulse_cap + 4));
               end else begin
                  dur = 16'($urandom_range(0, 63));
               end
               send_item(OP_FIRE, ch, dur, 1'b0, QUIET_RSP);
            end else begin
               send_tick();
            end
         end
         if ($urandom_range(0, 1) == 1) begin
            while (live_channels() != 0) send_tick();
         end
         phase++;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mcosl_pkg.sv
rtl/core/mcosl_core.sv
rtl/core/mcosl_skid.sv
rtl/core/multi_channel_one_shot_limiter_unit.sv
rtl/core/mcosl_checker.sv
test/multi_channel_one_shot_limiter_unit_tb.sv
